@@ rtl/core/baseline_trilateration_unit_assert.svh @@
// assertion macros for the trilateration unit
`ifndef BASELINE_TRILATERATION_UNIT_ASSERT_SVH
`define BASELINE_TRILATERATION_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BTU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BTU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BTU_ASSERT(label, clk, rst_n, prop)
`define BTU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/core/btu_pkg.sv @@
// types and constants shared by the trilateration unit
`timescale 1ns / 1ps
package btu_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MID_DEPTH     = 4;
    localparam int DIV_STAGES    = 33;
    localparam int SQRT_STAGES   = 32;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [64:0] num;
        logic        neg;
        logic [32:0] dvsr;
        logic        zero;
        logic [63:0] d0sq;
        logic        mirror;
    } t_mid_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        clamped;
        logic [1:0]  status;
    } t_result;
endpackage

@@ rtl/core/baseline_trilateration_unit.sv @@
// top level of the two-anchor trilateration unit
// usage:
//   requests enter through a queue-style port: drive the distances and mirror
//   with push high; a request is taken at a clock edge where full is low.
//   results leave the same way: while empty is low the oldest result is on
//   o_x_coord, o_y_coord, o_height_clamped and o_status; pop takes it.
//   the baseline is written with i_cfg_we and i_cfg_wdata, by the user only
//   while the unit idles; the block does not enforce this. each request samples it when taken.
// timing:
//   one request per cycle sustained while full stays low. each request passes
//   through the 33-stage divider and the 32-stage root pipeline.
// reset:
//   synchronous, active low; drops all work in flight and sets the baseline
//   to 1.0 in the fixed-point format.
// stalls:
//   when results are not popped the back end holds, the middle queue fills,
//   and full rises; nothing is lost.
`timescale 1ns / 1ps
module baseline_trilateration_unit #(
    parameter int FRAC_BITS = btu_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_dist_to_first,
    input  logic [31:0] i_dist_to_second,
    input  logic        i_mirror,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_x_coord,
    output logic [31:0] o_y_coord,
    output logic        o_height_clamped,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    logic [31:0]        r_baseline;
    btu_pkg::t_q_status q_status;
    btu_pkg::t_mid_item f_item, q_item;
    btu_pkg::t_result   result;
    logic               f_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= 32'd1 << FRAC_BITS;
        end else if (i_cfg_we) begin
            r_baseline <= i_cfg_wdata;
        end
    end

    btu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_dist_to_first  (i_dist_to_first),
        .i_dist_to_second (i_dist_to_second),
        .i_mirror         (i_mirror),
        .i_baseline       (r_baseline),
        .i_q_status       (q_status),
        .o_full           (full),
        .o_valid          (f_valid),
        .o_item           (f_item)
    );

    btu_queue #(
        .DEPTH (btu_pkg::MID_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid),
        .i_item   (f_item),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_item   (q_item)
    );

    btu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_item     (q_item),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (result)
    );

    assign o_x_coord        = result.x;
    assign o_y_coord        = result.y;
    assign o_height_clamped = result.clamped;
    assign o_status         = result.status;
endmodule

@@ rtl/core/btu_front.sv @@
// front end: squares and numerator of x for each request
`timescale 1ns / 1ps
module btu_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [31:0]          i_dist_to_first,
    input  logic [31:0]          i_dist_to_second,
    input  logic                 i_mirror,
    input  logic [31:0]          i_baseline,
    input  btu_pkg::t_q_status   i_q_status,
    output logic                 o_full,
    output logic                 o_valid,
    output btu_pkg::t_mid_item   o_item
);
    logic        en;
    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_d0, r_d1, r_l1, r_l2;
    logic        r_m1, r_m2;
    logic [63:0] r_ll, r_d0sq, r_d1sq;
    btu_pkg::t_mid_item r_item, n_item;
    logic [64:0] p, s;

    assign en      = !i_q_status.full;
    assign o_full  = !en;
    assign o_valid = r_v3 && en;
    assign o_item  = r_item;

    always_comb begin
        p = {1'b0, r_ll} + {1'b0, r_d0sq};
        s = {1'b0, r_d1sq};
        n_item.neg    = p < s;
        n_item.num    = n_item.neg ? (s - p) : (p - s);
        n_item.dvsr   = {r_l2, 1'b0};
        n_item.zero   = (r_l2 == 32'd0);
        n_item.d0sq   = r_d0sq;
        n_item.mirror = r_m2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0   <= i_dist_to_first;
            r_d1   <= i_dist_to_second;
            r_m1   <= i_mirror;
            r_l1   <= i_baseline;
            r_ll   <= r_l1 * r_l1;
            r_d0sq <= r_d0 * r_d0;
            r_d1sq <= r_d1 * r_d1;
            r_l2   <= r_l1;
            r_m2   <= r_m1;
            r_item <= n_item;
        end
    end
endmodule

@@ rtl/core/btu_queue.sv @@
// short queue between front and back end
`timescale 1ns / 1ps
`include "baseline_trilateration_unit_assert.svh"
module btu_queue #(
    parameter int DEPTH = btu_pkg::MID_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  btu_pkg::t_mid_item   i_item,
    input  logic                 i_pop,
    output btu_pkg::t_q_status   o_status,
    output btu_pkg::t_mid_item   o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    btu_pkg::t_mid_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `BTU_ASSERT(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_status.full)
    `BTU_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CW'(DEPTH))
    `BTU_ASSERT(a_cnt_step, i_clk, i_rst_n, (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
endmodule

@@ rtl/core/btu_back.sv @@
// back end: pipelined divider, saturation, pipelined square root, result buffer
`timescale 1ns / 1ps
module btu_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  btu_pkg::t_q_status   i_q_status,
    input  btu_pkg::t_mid_item   i_item,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output btu_pkg::t_result     o_result
);
    localparam int DS = btu_pkg::DIV_STAGES;
    localparam int SS = btu_pkg::SQRT_STAGES;

    logic en;

    // divider stages
    logic        r_dv   [DS+1];
    logic [64:0] r_rem  [DS+1];
    logic [32:0] r_q    [DS+1];
    logic [32:0] r_dd   [DS+1];
    logic        r_ovf  [DS+1];
    logic        r_neg  [DS+1];
    logic        r_zero [DS+1];
    logic [63:0] r_d0sq [DS+1];
    logic        r_dm   [DS+1];

    // saturation, square, compare
    logic        r_sv, r_mv, r_cv;
    logic [31:0] r_sx, r_mx, r_cx, r_xmag;
    logic [1:0]  r_sst, r_mst, r_cst;
    logic [63:0] r_sd0, r_md0, r_xsq;
    logic        r_sm, r_mm, r_cm, r_ccl;
    logic [63:0] r_rad;
    logic [31:0] n_x, n_xmag;
    logic [1:0]  n_st;

    // root stages
    logic        r_tv  [SS+1];
    logic [63:0] r_num [SS+1];
    logic [63:0] r_res [SS+1];
    logic [31:0] r_tx  [SS+1];
    logic [1:0]  r_tst [SS+1];
    logic        r_tcl [SS+1];
    logic        r_tm  [SS+1];

    // result buffer
    btu_pkg::t_result r_ob [2];
    btu_pkg::t_result n_res;
    logic       r_wp, r_rp;
    logic [1:0] r_ocnt;
    logic       ob_push, ob_pop;
    logic [31:0] ymag;

    assign en      = (r_ocnt != 2'd2);
    assign o_q_pop = en && !i_q_status.empty;
    assign o_empty = (r_ocnt == 2'd0);
    assign o_result = r_ob[r_rp];
    assign ob_push = en && r_tv[SS];
    assign ob_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DS; s++) begin
                r_dv[s] <= 1'b0;
            end
            for (int t = 0; t <= SS; t++) begin
                r_tv[t] <= 1'b0;
            end
            r_sv <= 1'b0;
            r_mv <= 1'b0;
            r_cv <= 1'b0;
        end else if (en) begin
            r_dv[0] <= !i_q_status.empty;
            for (int s = 0; s < DS; s++) begin
                r_dv[s+1] <= r_dv[s];
            end
            r_sv    <= r_dv[DS];
            r_mv    <= r_sv;
            r_cv    <= r_mv;
            r_tv[0] <= r_cv;
            for (int t = 0; t < SS; t++) begin
                r_tv[t+1] <= r_tv[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [64:0] sh;
        logic [63:0] bitv;
        logic [64:0] sum;
        if (en) begin
            r_rem[0]  <= i_item.num;
            r_q[0]    <= '0;
            r_dd[0]   <= i_item.dvsr;
            r_ovf[0]  <= ({1'b0, i_item.num[64:33]} >= i_item.dvsr);
            r_neg[0]  <= i_item.neg;
            r_zero[0] <= i_item.zero;
            r_d0sq[0] <= i_item.d0sq;
            r_dm[0]   <= i_item.mirror;
            for (int s = 0; s < DS; s++) begin
                sh = {32'd0, r_dd[s]} << (DS - 1 - s);
                if (r_rem[s] >= sh) begin
                    r_rem[s+1] <= r_rem[s] - sh;
                    r_q[s+1]   <= r_q[s] | (33'd1 << (DS - 1 - s));
                end else begin
                    r_rem[s+1] <= r_rem[s];
                    r_q[s+1]   <= r_q[s];
                end
                r_dd[s+1]   <= r_dd[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_neg[s+1]  <= r_neg[s];
                r_zero[s+1] <= r_zero[s];
                r_d0sq[s+1] <= r_d0sq[s];
                r_dm[s+1]   <= r_dm[s];
            end

            r_sx   <= n_x;
            r_xmag <= n_xmag;
            r_sst  <= n_st;
            r_sd0  <= r_d0sq[DS];
            r_sm   <= r_dm[DS];

            r_mx  <= r_sx;
            r_mst <= r_sst;
            r_md0 <= r_sd0;
            r_mm  <= r_sm;
            r_xsq <= r_xmag * r_xmag;

            r_cx  <= r_mx;
            r_cst <= r_mst;
            r_cm  <= r_mm;
            r_ccl <= (r_md0 <= r_xsq);
            r_rad <= (r_md0 <= r_xsq) ? 64'd0 : (r_md0 - r_xsq);

            r_num[0] <= r_rad;
            r_res[0] <= '0;
            r_tx[0]  <= r_cx;
            r_tst[0] <= r_cst;
            r_tcl[0] <= r_ccl;
            r_tm[0]  <= r_cm;
            for (int t = 0; t < SS; t++) begin
                bitv = 64'd1 << (2 * (SS - 1 - t));
                sum  = {1'b0, r_res[t]} + {1'b0, bitv};
                if ({1'b0, r_num[t]} >= sum) begin
                    r_num[t+1] <= r_num[t] - sum[63:0];
                    r_res[t+1] <= (r_res[t] >> 1) + bitv;
                end else begin
                    r_num[t+1] <= r_num[t];
                    r_res[t+1] <= r_res[t] >> 1;
                end
                r_tx[t+1]  <= r_tx[t];
                r_tst[t+1] <= r_tst[t];
                r_tcl[t+1] <= r_tcl[t];
                r_tm[t+1]  <= r_tm[t];
            end
        end
    end

    always_comb begin
        if (r_zero[DS]) begin
            n_x    = 32'd0;
            n_xmag = 32'd0;
            n_st   = btu_pkg::ST_ZERO;
        end else if (!r_neg[DS]) begin
            if (r_ovf[DS] || (r_q[DS] > 33'h07FFFFFFF)) begin
                n_x  = 32'h7FFFFFFF;
                n_st = btu_pkg::ST_SAT;
            end else begin
                n_x  = r_q[DS][31:0];
                n_st = btu_pkg::ST_OK;
            end
            n_xmag = n_x;
        end else begin
            if (r_ovf[DS] || (r_q[DS] > 33'h080000000)) begin
                n_xmag = 32'h80000000;
                n_st   = btu_pkg::ST_SAT;
            end else begin
                n_xmag = r_q[DS][31:0];
                n_st   = btu_pkg::ST_OK;
            end
            n_x = 32'd0 - n_xmag;
        end
    end

    always_comb begin
        ymag = (r_res[SS][63:31] != '0) ? 32'h7FFFFFFF : r_res[SS][31:0];
        n_res.x       = r_tx[SS];
        n_res.y       = r_tm[SS] ? (32'd0 - ymag) : ymag;
        n_res.clamped = r_tcl[SS];
        n_res.status  = r_tst[SS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (ob_push) begin
                r_wp <= !r_wp;
            end
            if (ob_pop) begin
                r_rp <= !r_rp;
            end
            if (ob_push && !ob_pop) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (ob_pop && !ob_push) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob[r_wp] <= n_res;
        end
    end
endmodule

@@ tb/tb_top.sv @@
// testbench for the two-anchor trilateration unit: directed table, random requests, predictor
`timescale 1ns / 1ps
module tb_top;
    typedef struct packed {
        logic [31:0] d0;
        logic [31:0] d1;
        logic        mirror;
        logic        known;
        btu_pkg::t_result res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [31:0] i_dist_to_first = '0;
    logic [31:0] i_dist_to_second = '0;
    logic        i_mirror = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        full;
    logic        empty;
    logic [31:0] o_x_coord;
    logic [31:0] o_y_coord;
    logic        o_height_clamped;
    logic [1:0]  o_status;

    logic [31:0] baseline;
    btu_pkg::t_result pending_pos[$];
    int          mismatches = 0;
    int          send_idle = 16;
    int          recv_idle = 68;
    int          hold_cycles = 0;
    t_row        dir_rows[$];

    baseline_trilateration_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_dist_to_first(i_dist_to_first), .i_dist_to_second(i_dist_to_second),
        .i_mirror(i_mirror), .empty(empty), .pop(pop),
        .o_x_coord(o_x_coord), .o_y_coord(o_y_coord),
        .o_height_clamped(o_height_clamped), .o_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic btu_pkg::t_result locate(logic [31:0] l, logic [31:0] d0,
                                                logic [31:0] d1, logic mir);
        btu_pkg::t_result o;
        logic [66:0] p;
        logic [66:0] s;
        logic [66:0] m;
        logic [66:0] q;
        logic        neg;
        logic signed [32:0] x;
        logic [31:0] xm;
        logic [63:0] d0sq;
        logic [63:0] xsq;
        logic [63:0] ym;
        o = '0;
        x = '0;
        ym = '0;
        if (l == 0) begin
            o.status = btu_pkg::ST_ZERO;
        end else begin
            p = 67'(l) * 67'(l) + 67'(d0) * 67'(d0);
            s = 67'(d1) * 67'(d1);
            neg = p < s;
            m = neg ? s - p : p - s;
            q = m / (67'(l) << 1);
            o.status = btu_pkg::ST_OK;
            if (!neg) begin
                if (q > 67'd2147483647) begin
                    x = 33'sd2147483647;
                    o.status = btu_pkg::ST_SAT;
                end else begin
                    x = 33'(q);
                end
            end else if (q > 67'd2147483648) begin
                x = -33'sd2147483648;
                o.status = btu_pkg::ST_SAT;
            end else begin
                x = -33'(q);
            end
        end
        xm = x < 0 ? 32'(-x) : 32'(x);
        d0sq = 64'(d0) * 64'(d0);
        xsq = 64'(xm) * 64'(xm);
        if (d0sq <= xsq) begin
            o.clamped = 1'b1;
        end else begin
            ym = root_floor(d0sq - xsq);
            if (ym > 64'd2147483647) ym = 64'd2147483647;
        end
        o.x = x[31:0];
        o.y = mir ? 32'(-ym) : ym[31:0];
        return o;
    endfunction

    task automatic send_request(logic [31:0] d0, logic [31:0] d1, logic mir, logic known,
                                btu_pkg::t_result res);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_dist_to_first <= d0;
        i_dist_to_second <= d1;
        i_mirror <= mir;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_pos.push_back(known ? res : locate(baseline, d0, d1, mir));
    endtask

    task automatic drain_and_set(logic [31:0] l);
        push <= 1'b0;
        while (pending_pos.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= l;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        baseline = l;
    endtask

    function automatic logic [31:0] rand_dist(logic [31:0] l);
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(32'h0004_0000);
            default: return l + $urandom_range(32'h0002_0000) - 32'h0001_0000;
        endcase
    endfunction

    // result side
    always @(posedge i_clk) begin
        btu_pkg::t_result got;
        btu_pkg::t_result want;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
        if (i_rst_n && pop && !empty) begin
            got = {o_x_coord, o_y_coord, o_height_clamped, o_status};
            if (pending_pos.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_pos.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: x %h/%h y %h/%h clamp %b/%b status %0d/%0d",
                                 want.x, got.x, want.y, got.y, want.clamped, got.clamped,
                                 want.status, got.status);
                end
            end
        end
    end

    initial begin
        logic [31:0] bl_set[6];
        t_row r;
        bl_set = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0003_8000, 32'h0010_0000};
        baseline = 32'h0001_0000;
        // reset baseline 1.0: d0 = d1 = 0, d0 = L with d1 = 0, saturating rows, rows checked by the predictor
        dir_rows.push_back('{32'h0, 32'h0, 1'b0, 1'b1,
                             '{32'h0000_8000, 32'h0, 1'b1, btu_pkg::ST_OK}});
        dir_rows.push_back('{32'h0, 32'h0, 1'b1, 1'b1,
                             '{32'h0000_8000, 32'h0, 1'b1, btu_pkg::ST_OK}});
        dir_rows.push_back('{32'h0001_0000, 32'h0, 1'b0, 1'b1,
                             '{32'h0001_0000, 32'h0, 1'b1, btu_pkg::ST_OK}});
        dir_rows.push_back('{32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1,
                             '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, btu_pkg::ST_SAT}});
        dir_rows.push_back('{32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1,
                             '{32'h8000_0000, 32'h0, 1'b1, btu_pkg::ST_SAT}});
        dir_rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0});
        dir_rows.push_back('{32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, '0});
        dir_rows.push_back('{32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0, '0});
        dir_rows.push_back('{32'h0000_8000, 32'h0001_8000, 1'b0, 1'b0, '0});
        dir_rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, '0});
        dir_rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, '0});
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            send_request(r.d0, r.d1, r.mirror, r.known, r.res);
        end
        drain_and_set(32'h0000_0000);
        // zero baseline: x 0, y equals d0 saturated
        send_request(32'h0, 32'h1234, 1'b0, 1'b1, '{32'h0, 32'h0, 1'b1, btu_pkg::ST_ZERO});
        send_request(32'hFFFF_FFFF, 32'h1, 1'b1, 1'b1,
                     '{32'h0, 32'h8000_0001, 1'b0, btu_pkg::ST_ZERO});
        send_request(32'h0002_0000, 32'h0, 1'b1, 1'b0, '0);
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                send_idle = 68;
                recv_idle = 16;
            end else if (ph == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            drain_and_set(bl_set[(ph + 1) % 6]);
            if (ph == 4) hold_cycles = 400;
            for (int n = 0; n < 170; n++)
                send_request(rand_dist(baseline), rand_dist(baseline), $urandom_range(1),
                             1'b0, '0);
        end
        push <= 1'b0;
        while (pending_pos.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
